@@ rtl/core/dffd_pkg.sv @@
// ----------------------------------------------------------------------------
// dffd_pkg
// Shared types and constants for the dual force frame decoder: frame
// header codes, framer states, the frame handoff struct and Q24.8 limits.
// ----------------------------------------------------------------------------
package dffd_pkg;

	// Frame header and checksum seed
	localparam logic [7:0] HDR_FIRST     = 8'hAB;
	localparam logic [7:0] HDR_SECOND    = 8'hCD;
	localparam logic [7:0] SUM_SEED      = HDR_FIRST + HDR_SECOND;
	localparam int         PAYLOAD_BYTES = 8;
	localparam int         IDX_W         = $clog2(PAYLOAD_BYTES + 1);
	localparam int         SLOT_W        = $clog2(PAYLOAD_BYTES);

	// Deadband reset value: 100.0 in Q24.8
	localparam logic [30:0] DEADBAND_RESET = 31'd25600;

	// Q24.8 limits
	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	// Biased exponents that bound the single to Q24.8 conversion
	localparam logic [7:0] EXP_UNITY = 8'd142;  // significand lands exactly on Q24.8
	localparam logic [7:0] EXP_TOP   = 8'd150;  // largest exponent that may still fit
	localparam logic [7:0] EXP_FLOOR = 8'd118;  // at or below this, all bits shift out
	localparam logic [7:0] EXP_SPEC  = 8'hFF;   // infinity and NaN

	// Framer states, one-hot
	typedef enum logic [2:0] {
		ST_HUNT    = 3'b001,
		ST_HDR2    = 3'b010,
		ST_PAYLOAD = 3'b100
	} sync_state_t;

	// A checked frame handed from the framer to the pipeline
	typedef struct packed {
		logic        valid;
		logic [31:0] word0;
		logic [31:0] word1;
	} frame_t;

endpackage

@@ rtl/core/dffd_conv.sv @@
// ----------------------------------------------------------------------------
// dffd_conv
// Converts one IEEE single to signed Q24.8, truncating toward zero and
// saturating on overflow, infinity or NaN, then applies the deadband.
// ----------------------------------------------------------------------------
module dffd_conv
	import dffd_pkg::*;
(
	input  logic [31:0]        word,
	input  logic [30:0]        threshold,
	output logic signed [31:0] force_q
);

	logic        neg;
	logic [7:0]  ex;
	logic [31:0] sig;
	logic        sat;
	logic [31:0] mag;
	logic [31:0] val;
	logic [31:0] abs_val;

	assign neg = word[31];
	assign ex  = word[30:23];
	assign sig = {8'd0, 1'b1, word[22:0]};

	// Align the significand to the Q24.8 point
	always_comb begin
		sat = 1'b0;
		mag = '0;
		if (ex == EXP_SPEC || ex > EXP_TOP) begin
			sat = 1'b1;
		end else if (ex <= EXP_FLOOR) begin
			mag = '0;
		end else if (ex >= EXP_UNITY) begin
			mag = sig << 4'(ex - EXP_UNITY);
		end else begin
			mag = sig >> 5'(EXP_UNITY - ex);
		end
	end

	// Apply sign and saturate to the 32-bit range
	always_comb begin
		if (sat) begin
			val = neg ? Q_MIN : Q_MAX;
		end else if (neg) begin
			val = (mag > 32'h8000_0000) ? Q_MIN : (32'd0 - mag);
		end else begin
			val = mag[31] ? Q_MAX : mag;
		end
	end

	// Deadband on magnitude; the most negative value has magnitude 2^31
	assign abs_val = val[31] ? (32'd0 - val) : val;
	assign force_q = (abs_val < {1'b0, threshold}) ? 32'sd0 : $signed(val);

endmodule

@@ rtl/core/dffd_framer.sv @@
// ----------------------------------------------------------------------------
// dffd_framer
// Byte-level frame sync: hunts the two header bytes, stores eight payload
// bytes, checks the running sum and hands a good frame to the pipeline.
// ----------------------------------------------------------------------------
module dffd_framer
	import dffd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_take,
	input  logic [7:0] rx_byte,
	output frame_t     frame
);

	sync_state_t      state_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       sum_q;
	logic [7:0]       store_q [PAYLOAD_BYTES];
	logic             last_byte;

	assign last_byte = (idx_q == IDX_W'(PAYLOAD_BYTES));

	// Sync state, index and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			idx_q   <= '0;
			sum_q   <= '0;
		end else if (byte_take) begin
			unique case (state_q)
				ST_HUNT: begin
					if (rx_byte == HDR_FIRST) state_q <= ST_HDR2;
				end
				ST_HDR2: begin
					if (rx_byte == HDR_SECOND) begin
						state_q <= ST_PAYLOAD;
						idx_q   <= '0;
						sum_q   <= SUM_SEED;
					end else begin
						state_q <= ST_HUNT;
					end
				end
				ST_PAYLOAD: begin
					if (last_byte) begin
						state_q <= ST_HUNT;
						idx_q   <= '0;
					end else begin
						sum_q <= sum_q + rx_byte;
						idx_q <= idx_q + 1'b1;
					end
				end
				default: state_q <= ST_HUNT;
			endcase
		end
	end

	// Payload bytes; the checksum byte is not stored
	always_ff @(posedge clk) begin
		if (byte_take && state_q == ST_PAYLOAD && !last_byte) begin
			store_q[idx_q[SLOT_W-1:0]] <= rx_byte;
		end
	end

	// Frame handoff on a checksum match
	assign frame.valid = byte_take && state_q == ST_PAYLOAD && last_byte && rx_byte == sum_q;
	assign frame.word0 = {store_q[3], store_q[2], store_q[1], store_q[0]};
	assign frame.word1 = {store_q[7], store_q[6], store_q[5], store_q[4]};

endmodule

@@ rtl/core/dual_force_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// dual_force_frame_decoder
// Decodes framed pairs of single-precision forces into hand count, force
// and turn values in signed Q24.8.
// ----------------------------------------------------------------------------
// Path: a checked frame is registered, converted, then combined.
// Throughput: one byte per cycle; the three-stage pipeline (frame, convert,
// combine) never holds the input except under output stall.
// Reset: asynchronous, active low; clears framer sync, pipeline valids and
// loads the deadband register with 100.0 (25600 in Q24.8).
// ----------------------------------------------------------------------------
module dual_force_frame_decoder
	import dffd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [30:0]        cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         hand_count,
	output logic signed [31:0] force_value,
	output logic signed [31:0] turn_value
);

	logic [30:0]        thr_q;
	frame_t             frame;
	logic               byte_take;
	logic               v_s1;
	logic [31:0]        w0_s1;
	logic [31:0]        w1_s1;
	logic               v_s2;
	logic signed [31:0] f1_s2;
	logic signed [31:0] f2_s2;
	logic signed [31:0] f1_c;
	logic signed [31:0] f2_c;
	logic               out_ready;
	logic               ready_s2;
	logic               ready_s1;
	logic [1:0]         hands_c;
	logic signed [31:0] force_c;
	logic signed [31:0] turn_c;
	logic signed [32:0] diff;
	logic signed [32:0] sum_s;
	logic [32:0]        a1;
	logic [32:0]        a2;
	logic [33:0]        sum_a;
	logic signed [32:0] half_s;
	logic signed [31:0] turn_sat;
	logic               z1;
	logic               z2;

	// Deadband register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= DEADBAND_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	// Pipeline flow control
	assign out_ready = !out_valid || !out_stall;
	assign ready_s2  = !v_s2 || out_ready;
	assign ready_s1  = !v_s1 || ready_s2;
	assign in_stall  = !ready_s1;
	assign byte_take = in_valid && ready_s1;

	dffd_framer u_framer (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_take (byte_take),
		.rx_byte   (rx_byte),
		.frame     (frame)
	);

	// Stage 1: checked frame words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			v_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && frame.valid) begin
			w0_s1 <= frame.word0;
			w1_s1 <= frame.word1;
		end
	end

	dffd_conv u_conv0 (
		.word      (w0_s1),
		.threshold (thr_q),
		.force_q   (f1_c)
	);

	dffd_conv u_conv1 (
		.word      (w1_s1),
		.threshold (thr_q),
		.force_q   (f2_c)
	);

	// Stage 2: converted forces
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) begin
			f1_s2 <= f1_c;
			f2_s2 <= f2_c;
		end
	end

	// Combine the two forces
	assign z1     = (f1_s2 == 32'sd0);
	assign z2     = (f2_s2 == 32'sd0);
	assign diff   = 33'(f1_s2) - 33'(f2_s2);
	assign sum_s  = 33'(f1_s2) + 33'(f2_s2);
	assign a1     = f1_s2[31] ? (33'd0 - 33'(f1_s2)) : 33'(f1_s2);
	assign a2     = f2_s2[31] ? (33'd0 - 33'(f2_s2)) : 33'(f2_s2);
	assign sum_a  = {1'b0, a1} + {1'b0, a2};
	// Truncate toward zero: bump odd negative sums before the shift
	assign half_s = (sum_s + 33'(sum_s[32] & sum_s[0])) >>> 1;
	assign turn_sat = (diff[32] != diff[31]) ? (diff[32] ? Q_MIN : Q_MAX) : diff[31:0];

	always_comb begin
		if (z1 && z2) begin
			hands_c = 2'd0;
			force_c = 32'sd0;
			turn_c  = 32'sd0;
		end else if (z1 || z2) begin
			hands_c = 2'd1;
			force_c = z2 ? f1_s2 : f2_s2;
			turn_c  = turn_sat;
		end else if (f1_s2[31] != f2_s2[31]) begin
			hands_c = 2'd2;
			force_c = (sum_a[33:1] > 33'(Q_MAX)) ? Q_MAX : $signed(sum_a[32:1]);
			turn_c  = turn_sat;
		end else begin
			hands_c = 2'd2;
			force_c = half_s[31:0];
			turn_c  = 32'sd0;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_ready) begin
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && v_s2) begin
			hand_count  <= hands_c;
			force_value <= force_c;
			turn_value  <= turn_c;
		end
	end

endmodule

@@ rtl/core/dffd_checker.sv @@
// ----------------------------------------------------------------------------
// dffd_checker
// Port-level checks for the dual force frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module dffd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         hand_count,
	input logic signed [31:0] force_value,
	input logic signed [31:0] turn_value
);

	// A stalled result holds until its transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hand_count)
			&& $stable(force_value) && $stable(turn_value))
		else $error("stalled result changed");

	// Hand count never exceeds two
	a_hands: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hand_count != 2'd3)
		else $error("hand count out of range");

	// No hands means no force and no turn
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hand_count == 2'd0 |-> force_value == 32'sd0 && turn_value == 32'sd0)
		else $error("nonzero output with no hands");

	// One hand carries a nonzero force
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hand_count == 2'd1 |-> force_value != 32'sd0)
		else $error("one hand with zero force");

endmodule

bind dual_force_frame_decoder dffd_checker u_dffd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.hand_count  (hand_count),
	.force_value (force_value),
	.turn_value  (turn_value)
);
